>>> sv/ile_pkg.sv
`default_nettype none

package ile_pkg;

    // Field widths of the stream payloads
    localparam int REQ_W      = 3;
    localparam int VAL_W      = 32;
    localparam int POS_IN_W   = 5;
    localparam int POS_OUT_W  = 4;
    localparam int CNT_W      = 5;
    localparam int STAT_W     = 2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VAL_W - POS_OUT_W - CNT_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ     = 3'd0,
        REQ_INS_HEAD = 3'd1,
        REQ_INS_AT   = 3'd2,
        REQ_APPEND   = 3'd3,
        REQ_DELETE   = 3'd4
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Source of the value field of a result
    typedef enum logic [1:0] {
        VSEL_ZERO  = 2'd0,
        VSEL_REQ   = 2'd1,
        VSEL_GONE  = 2'd2,
        VSEL_RDATA = 2'd3
    } t_vsel;

    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_INS       = 3'd1,
        S_DEL_FIRST = 3'd2,
        S_DEL       = 3'd3,
        S_READ      = 3'd4,
        S_RESP      = 3'd5
    } t_state;

    typedef struct packed {
        logic                 capture;
        logic                 rd_en;
        logic                 wr_en;
        logic                 wr_req;
        logic                 gone_load;
        logic                 len_inc;
        logic                 len_dec;
        logic                 out_load;
        t_vsel                vsel;
        t_status              status;
        logic [POS_OUT_W-1:0] out_pos;
        logic                 out_last;
    } t_cmd;

endpackage

`default_nettype wire

>>> sv/ile_dpath.sv
`default_nettype none

module ile_dpath #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int LW       = 5
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ile_pkg::t_cmd                  i_cmd,
    input  wire logic [AW-1:0]                  i_rd_addr,
    input  wire logic [AW-1:0]                  i_wr_addr,
    input  wire logic [ile_pkg::VAL_W-1:0]      i_value,
    input  wire logic                           i_tready,
    output logic [LW-1:0]                       o_len,
    output logic                                o_out_free,
    output logic                                o_tvalid,
    output ile_pkg::t_status                    o_status,
    output logic [ile_pkg::VAL_W-1:0]           o_value,
    output logic [ile_pkg::POS_OUT_W-1:0]       o_pos,
    output logic [ile_pkg::CNT_W-1:0]           o_count,
    output logic                                o_last
);

    logic [ile_pkg::VAL_W-1:0]     r_mem [CAPACITY];
    logic [ile_pkg::VAL_W-1:0]     r_rdata;
    logic [ile_pkg::VAL_W-1:0]     r_value;
    logic [ile_pkg::VAL_W-1:0]     r_gone;
    logic [LW-1:0]                 r_len;
    logic                          r_ovalid;
    ile_pkg::t_status              r_ostat;
    logic [ile_pkg::VAL_W-1:0]     r_oval;
    logic [ile_pkg::POS_OUT_W-1:0] r_opos;
    logic [ile_pkg::CNT_W-1:0]     r_ocnt;
    logic                          r_olast;
    logic [ile_pkg::VAL_W-1:0]     wr_data;
    logic [ile_pkg::VAL_W-1:0]     out_val;

    assign wr_data = i_cmd.wr_req ? r_value : r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_value <= i_value;
        end
        if (i_cmd.gone_load) begin
            r_gone <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.len_inc) begin
            r_len <= r_len + LW'(1);
        end else if (i_cmd.len_dec) begin
            r_len <= r_len - LW'(1);
        end
    end

    always_comb begin
        case (i_cmd.vsel)
            ile_pkg::VSEL_REQ:   out_val = r_value;
            ile_pkg::VSEL_GONE:  out_val = r_gone;
            ile_pkg::VSEL_RDATA: out_val = r_rdata;
            default:             out_val = '0;
        endcase
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ostat <= i_cmd.status;
            r_oval  <= out_val;
            r_opos  <= i_cmd.out_pos;
            r_ocnt  <= ile_pkg::CNT_W'(r_len);
            r_olast <= i_cmd.out_last;
        end
    end

    assign o_len      = r_len;
    assign o_out_free = !r_ovalid || i_tready;
    assign o_tvalid   = r_ovalid;
    assign o_status   = r_ostat;
    assign o_value    = r_oval;
    assign o_pos      = r_opos;
    assign o_count    = r_ocnt;
    assign o_last     = r_olast;

endmodule

`default_nettype wire

>>> sv/ile_ctrl.sv
`default_nettype none

module ile_ctrl #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int LW       = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [ile_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [ile_pkg::POS_IN_W-1:0]  i_position,
    input  wire logic [LW-1:0]                 i_len,
    input  wire logic                          i_out_free,
    output ile_pkg::t_cmd                      o_cmd,
    output logic [AW-1:0]                      o_rd_addr,
    output logic [AW-1:0]                      o_wr_addr
);

    localparam int CW = (LW > ile_pkg::POS_IN_W) ? LW : ile_pkg::POS_IN_W;

    ile_pkg::t_state  r_state, n_state;
    logic [LW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_pos, n_pos;
    logic [AW-1:0]    r_waddr, n_waddr;
    logic [AW-1:0]    r_ridx, n_ridx;
    logic             r_wpend, n_wpend;
    logic             r_first, n_first;
    logic             r_rdv, n_rdv;
    ile_pkg::t_status r_status, n_status;
    ile_pkg::t_vsel   r_vsel, n_vsel;

    ile_pkg::t_state  d_next;
    ile_pkg::t_status d_status;
    ile_pkg::t_vsel   d_vsel;
    logic [CW-1:0]    len_ext;
    logic [CW-1:0]    pos_ext;
    logic [CW-1:0]    ep;
    logic             full;
    logic             ins_more;
    logic             ins_done;
    logic             del_more;
    logic             del_done;
    logic             rd_load;
    logic             rd_last;
    logic             rd_issue;

    assign len_ext  = CW'(i_len);
    assign pos_ext  = CW'(i_position);
    assign full     = (i_len == LW'(CAPACITY));

    assign ins_more = (r_idx > LW'(r_pos));
    assign ins_done = !ins_more && !r_wpend;
    assign del_more = (r_idx < i_len);
    assign del_done = !del_more && !r_wpend && !r_first;
    assign rd_load  = r_rdv && i_out_free;
    assign rd_last  = ((LW'(r_ridx) + LW'(1)) == i_len);
    assign rd_issue = (r_idx < i_len) && (!r_rdv || rd_load);

    assign o_ready  = (r_state == ile_pkg::S_IDLE);

    // Request decode at acceptance
    always_comb begin
        d_next   = ile_pkg::S_IDLE;
        d_status = ile_pkg::ST_OK;
        d_vsel   = ile_pkg::VSEL_ZERO;
        if (ile_pkg::t_req'(i_req_type) == ile_pkg::REQ_INS_HEAD) begin
            ep = '0;
        end else if (ile_pkg::t_req'(i_req_type) == ile_pkg::REQ_APPEND) begin
            ep = len_ext;
        end else begin
            ep = pos_ext;
        end
        unique case (ile_pkg::t_req'(i_req_type)) inside
            ile_pkg::REQ_READ: begin
                if (i_len == '0) begin
                    d_next   = ile_pkg::S_RESP;
                    d_status = ile_pkg::ST_EMPTY;
                end else begin
                    d_next = ile_pkg::S_READ;
                end
            end
            ile_pkg::REQ_INS_HEAD, ile_pkg::REQ_INS_AT, ile_pkg::REQ_APPEND: begin
                if (full) begin
                    d_next   = ile_pkg::S_RESP;
                    d_status = ile_pkg::ST_FULL;
                end else if (ep > len_ext) begin
                    d_next   = ile_pkg::S_RESP;
                    d_status = ile_pkg::ST_BADPOS;
                end else begin
                    d_next = ile_pkg::S_INS;
                    d_vsel = ile_pkg::VSEL_REQ;
                end
            end
            ile_pkg::REQ_DELETE: begin
                if (i_len == '0) begin
                    d_next   = ile_pkg::S_RESP;
                    d_status = ile_pkg::ST_EMPTY;
                end else if (pos_ext >= len_ext) begin
                    d_next   = ile_pkg::S_RESP;
                    d_status = ile_pkg::ST_BADPOS;
                end else begin
                    d_next = ile_pkg::S_DEL_FIRST;
                    d_vsel = ile_pkg::VSEL_GONE;
                end
            end
            default: begin
                d_next = ile_pkg::S_IDLE;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ile_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = d_next;
                end
            end
            ile_pkg::S_INS: begin
                if (ins_done) begin
                    n_state = ile_pkg::S_RESP;
                end
            end
            ile_pkg::S_DEL_FIRST: begin
                n_state = ile_pkg::S_DEL;
            end
            ile_pkg::S_DEL: begin
                if (del_done) begin
                    n_state = ile_pkg::S_RESP;
                end
            end
            ile_pkg::S_READ: begin
                if (rd_load && rd_last) begin
                    n_state = ile_pkg::S_IDLE;
                end
            end
            ile_pkg::S_RESP: begin
                if (i_out_free) begin
                    n_state = ile_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ile_pkg::S_IDLE;
            end
        endcase
    end

    // Commands and counter updates
    always_comb begin
        o_cmd.capture   = 1'b0;
        o_cmd.rd_en     = 1'b0;
        o_cmd.wr_en     = 1'b0;
        o_cmd.wr_req    = 1'b0;
        o_cmd.gone_load = 1'b0;
        o_cmd.len_inc   = 1'b0;
        o_cmd.len_dec   = 1'b0;
        o_cmd.out_load  = 1'b0;
        o_cmd.vsel      = r_vsel;
        o_cmd.status    = r_status;
        o_cmd.out_pos   = '0;
        o_cmd.out_last  = 1'b1;
        o_rd_addr       = r_pos;
        o_wr_addr       = r_waddr;
        n_idx           = r_idx;
        n_pos           = r_pos;
        n_waddr         = r_waddr;
        n_ridx          = r_ridx;
        n_wpend         = r_wpend;
        n_first         = r_first;
        n_rdv           = r_rdv;
        n_status        = r_status;
        n_vsel          = r_vsel;
        unique case (r_state)
            ile_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_status      = d_status;
                    n_vsel        = d_vsel;
                    n_pos         = AW'(ep);
                    n_wpend       = 1'b0;
                    n_first       = 1'b0;
                    n_rdv         = 1'b0;
                    if (d_next == ile_pkg::S_READ) begin
                        n_idx = '0;
                    end else begin
                        n_idx = i_len;
                    end
                end
            end
            ile_pkg::S_INS: begin
                // Move entries up one place, from the tail toward the insert point
                if (r_wpend) begin
                    o_cmd.wr_en = 1'b1;
                    o_wr_addr   = r_waddr;
                end
                if (ins_more) begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = AW'(r_idx - LW'(1));
                    n_wpend     = 1'b1;
                    n_waddr     = AW'(r_idx);
                    n_idx       = r_idx - LW'(1);
                end else begin
                    n_wpend = 1'b0;
                    if (!r_wpend) begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.wr_req  = 1'b1;
                        o_wr_addr     = r_pos;
                        o_cmd.len_inc = 1'b1;
                    end
                end
            end
            ile_pkg::S_DEL_FIRST: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr   = r_pos;
                n_idx       = LW'(r_pos) + LW'(1);
                n_first     = 1'b1;
                n_wpend     = 1'b0;
            end
            ile_pkg::S_DEL: begin
                // Keep the removed entry, then move the tail down one place
                if (r_first) begin
                    o_cmd.gone_load = 1'b1;
                    n_first         = 1'b0;
                end
                if (r_wpend) begin
                    o_cmd.wr_en = 1'b1;
                    o_wr_addr   = r_waddr;
                end
                if (del_more) begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = AW'(r_idx);
                    n_wpend     = 1'b1;
                    n_waddr     = AW'(r_idx - LW'(1));
                    n_idx       = r_idx + LW'(1);
                end else begin
                    n_wpend = 1'b0;
                    if (!r_wpend && !r_first) begin
                        o_cmd.len_dec = 1'b1;
                    end
                end
            end
            ile_pkg::S_READ: begin
                o_cmd.vsel   = ile_pkg::VSEL_RDATA;
                o_cmd.status = ile_pkg::ST_OK;
                if (rd_load) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_pos  = ile_pkg::POS_OUT_W'(r_ridx);
                    o_cmd.out_last = rd_last;
                end
                if (rd_issue) begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = AW'(r_idx);
                    n_ridx      = AW'(r_idx);
                    n_idx       = r_idx + LW'(1);
                    n_rdv       = 1'b1;
                end else if (rd_load) begin
                    n_rdv = 1'b0;
                end
            end
            ile_pkg::S_RESP: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_status == ile_pkg::ST_OK) begin
                        o_cmd.out_pos = ile_pkg::POS_OUT_W'(r_pos);
                    end
                end
            end
            default: begin
                n_wpend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ile_pkg::S_IDLE;
            r_wpend <= 1'b0;
            r_first <= 1'b0;
            r_rdv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wpend <= n_wpend;
            r_first <= n_first;
            r_rdv   <= n_rdv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_waddr  <= n_waddr;
        r_ridx   <= n_ridx;
        r_status <= n_status;
        r_vsel   <= n_vsel;
    end

endmodule

`default_nettype wire

>>> sv/indexed_list_engine.sv
`default_nettype none

// Channel  Dir  Handshake                     Payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata: value, position; tuser: req_type
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: value_res, position_res, count;
//                                             tuser: status; tlast: last
//
// Sequencing: insert and delete at position p shift the entries from p to the tail, read-out
// streams every entry, and errors go straight to the response; the single memory port pair
// moves one entry per cycle during a shift, and during a read-out while the output is free.
// Reset: synchronous, active low; clears the length at once, no clearing pass.
// Stalls: a result waits in the output register while m_axis_tready is low; a new
// transaction is taken whenever the controller is idle, even with a result waiting.

module indexed_list_engine #(
    parameter int CAPACITY = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [31:0] value, [36:32] position, [39:37] zero
    input  wire logic [ile_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [2:0] req_type
    input  wire logic [ile_pkg::REQ_W-1:0]           s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [31:0] value_res, [35:32] position_res, [40:36] count, [47:41] zero
    output logic [ile_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // [1:0] status
    output logic [ile_pkg::STAT_W-1:0]               m_axis_tuser,
    output logic                                     m_axis_tlast
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    ile_pkg::t_cmd                 cmd;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 wr_addr;
    logic [LW-1:0]                 len;
    logic                          out_free;
    ile_pkg::t_status              out_status;
    logic [ile_pkg::VAL_W-1:0]     out_value;
    logic [ile_pkg::POS_OUT_W-1:0] out_pos;
    logic [ile_pkg::CNT_W-1:0]     out_count;

    // Sequencer: decodes each transaction and steps the shift or read-out
    ile_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .LW       (LW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_req_type (s_axis_tuser),
        .i_position (s_axis_tdata[ile_pkg::VAL_W +: ile_pkg::POS_IN_W]),
        .i_len      (len),
        .i_out_free (out_free),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr)
    );

    // Entry memory, length counter and the output register
    ile_dpath #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .LW       (LW)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .i_value    (s_axis_tdata[ile_pkg::VAL_W-1:0]),
        .i_tready   (m_axis_tready),
        .o_len      (len),
        .o_out_free (out_free),
        .o_tvalid   (m_axis_tvalid),
        .o_status   (out_status),
        .o_value    (out_value),
        .o_pos      (out_pos),
        .o_count    (out_count),
        .o_last     (m_axis_tlast)
    );

    // Pack the result fields, lowest first
    assign m_axis_tdata = {{ile_pkg::OUT_PAD_W{1'b0}}, out_count, out_pos, out_value};
    assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

>>> tb/tb_indexed_list_engine.sv
`timescale 1ns / 100ps

module tb_indexed_list_engine;

    localparam int LIST_CAP      = 16;
    localparam int DRAIN_CYCLES  = 2 * LIST_CAP + 16;  // longest request plus margin
    localparam int LONG_HOLD     = 160;                // receiver hold-off for back-pressure
    localparam realtime RUN_LIMIT = 4ms;

    // One expected result of a list request
    typedef struct {
        ile_pkg::t_status              status;
        logic [ile_pkg::VAL_W-1:0]     value;
        logic [ile_pkg::POS_OUT_W-1:0] index;
        logic [ile_pkg::CNT_W-1:0]     count;
        logic                          last;
    } t_list_result;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // [31:0] value, [36:32] position, [39:37] zero
    logic [ile_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    // [2:0] req_type
    logic [ile_pkg::REQ_W-1:0]       s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // [31:0] value_res, [35:32] position_res, [40:36] count, [47:41] zero
    logic [ile_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    // [1:0] status
    logic [ile_pkg::STAT_W-1:0]      m_axis_tuser;
    logic                            m_axis_tlast;

    // Shadow copy of the list, updated at each accepted request transaction
    logic [ile_pkg::VAL_W-1:0] shadow_list [LIST_CAP];
    int unsigned               shadow_len;

    // Results still owed by the block, oldest first
    t_list_result pending_results [$];

    int          mismatch_count;
    int unsigned snd_idle_pct;
    int unsigned rcv_stall_pct;
    int unsigned rcv_hold_cycles;

    indexed_list_engine #(
        .CAPACITY(LIST_CAP)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop: the slowest legal run finishes far below this
    initial begin
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    function automatic void owe_result(ile_pkg::t_status status,
                                       logic [ile_pkg::VAL_W-1:0] value,
                                       int unsigned index, logic last);
        t_list_result r;
        r.status = status;
        r.value  = value;
        r.index  = index[ile_pkg::POS_OUT_W-1:0];
        r.count  = shadow_len[ile_pkg::CNT_W-1:0];
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    // Insert rejects a full list first, then a position past the tail
    function automatic void shadow_insert(int unsigned pos, logic [ile_pkg::VAL_W-1:0] value);
        if (shadow_len >= LIST_CAP) begin
            owe_result(ile_pkg::ST_FULL, '0, 0, 1'b1);
        end else if (pos > shadow_len) begin
            owe_result(ile_pkg::ST_BADPOS, '0, 0, 1'b1);
        end else begin
            for (int i = shadow_len; i > pos; i--)
                shadow_list[i] = shadow_list[i-1];
            shadow_list[pos] = value;
            shadow_len++;
            owe_result(ile_pkg::ST_OK, value, pos, 1'b1);
        end
    endfunction

    function automatic void shadow_delete(int unsigned pos);
        logic [ile_pkg::VAL_W-1:0] gone;
        if (shadow_len == 0) begin
            owe_result(ile_pkg::ST_EMPTY, '0, 0, 1'b1);
        end else if (pos >= shadow_len) begin
            owe_result(ile_pkg::ST_BADPOS, '0, 0, 1'b1);
        end else begin
            gone = shadow_list[pos];
            for (int i = pos; i + 1 < shadow_len; i++)
                shadow_list[i] = shadow_list[i+1];
            shadow_len--;
            owe_result(ile_pkg::ST_OK, gone, pos, 1'b1);
        end
    endfunction

    // Work out every result one accepted request causes
    function automatic void predict_list_op(logic [ile_pkg::REQ_W-1:0] req,
                                            logic [ile_pkg::VAL_W-1:0] value,
                                            logic [ile_pkg::POS_IN_W-1:0] pos);
        case (req)
            ile_pkg::REQ_READ: begin
                if (shadow_len == 0)
                    owe_result(ile_pkg::ST_EMPTY, '0, 0, 1'b1);
                else
                    for (int i = 0; i < shadow_len; i++)
                        owe_result(ile_pkg::ST_OK, shadow_list[i], i, i + 1 == shadow_len);
            end
            ile_pkg::REQ_INS_HEAD: shadow_insert(0, value);
            ile_pkg::REQ_INS_AT:   shadow_insert(pos, value);
            ile_pkg::REQ_APPEND:   shadow_insert(shadow_len, value);
            ile_pkg::REQ_DELETE:   shadow_delete(pos);
            default: ;  // unknown request types cause nothing
        endcase
    endfunction

    //------------------------------------------------------------------
    // Result side: stall control and checking
    //------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [ile_pkg::VAL_W-1:0] got,
                                   logic [ile_pkg::VAL_W-1:0] want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Drive tready: a long hold-off when one is pending, else random stalls
    always @(negedge i_clk) begin
        if (rcv_hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            rcv_hold_cycles = rcv_hold_cycles - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", m_axis_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", ile_pkg::VAL_W'(m_axis_tuser),
                                    ile_pkg::VAL_W'(want.status));
                if (m_axis_tdata[31:0] !== want.value)
                    report_mismatch("value_res", m_axis_tdata[31:0], want.value);
                if (m_axis_tdata[35:32] !== want.index)
                    report_mismatch("position_res", ile_pkg::VAL_W'(m_axis_tdata[35:32]),
                                    ile_pkg::VAL_W'(want.index));
                if (m_axis_tdata[40:36] !== want.count)
                    report_mismatch("count", ile_pkg::VAL_W'(m_axis_tdata[40:36]),
                                    ile_pkg::VAL_W'(want.count));
                if (m_axis_tlast !== want.last)
                    report_mismatch("tlast", ile_pkg::VAL_W'(m_axis_tlast),
                                    ile_pkg::VAL_W'(want.last));
            end
        end
    end

    //------------------------------------------------------------------
    // Request side
    //------------------------------------------------------------------

    // Offer one request transaction; call and return at a falling edge
    task automatic send_request(logic [ile_pkg::REQ_W-1:0] req,
                                logic [ile_pkg::VAL_W-1:0] value,
                                logic [ile_pkg::POS_IN_W-1:0] pos);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, pos, value};
        s_axis_tuser  <= req;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        predict_list_op(req, value, pos);
        @(negedge i_clk);
    endtask

    // Pause the sender until every owed result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [ile_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // One random request: mostly well-formed, leaning toward growth by grow_pct
    task automatic random_request(int unsigned grow_pct);
        int unsigned roll;
        logic [ile_pkg::REQ_W-1:0] req;
        logic [ile_pkg::POS_IN_W-1:0] pos;
        roll = $urandom_range(0, 99);
        pos  = ile_pkg::POS_IN_W'($urandom_range(0, 31));
        if (roll < 3) begin
            req = ile_pkg::REQ_W'($urandom_range(5, 7));
        end else if (roll < 12) begin
            req = ile_pkg::REQ_READ;
        end else if (roll < 20) begin
            // noise: any edit with an arbitrary position
            req = ile_pkg::REQ_W'($urandom_range(ile_pkg::REQ_INS_HEAD, ile_pkg::REQ_DELETE));
        end else if ($urandom_range(0, 99) < grow_pct) begin
            req = ile_pkg::REQ_W'($urandom_range(ile_pkg::REQ_INS_HEAD, ile_pkg::REQ_APPEND));
            pos = ile_pkg::POS_IN_W'($urandom_range(0, shadow_len));
        end else begin
            req = ile_pkg::REQ_DELETE;
            pos = ile_pkg::POS_IN_W'((shadow_len == 0) ? 0 : $urandom_range(0, shadow_len - 1));
        end
        send_request(req, pick_value(), pos);
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Read, delete and out-of-range insert on an empty list
    task automatic test_empty_list();
        send_request(ile_pkg::REQ_READ, 32'h1234_5678, 5'd0);
        send_request(ile_pkg::REQ_DELETE, '0, 5'd0);
        send_request(ile_pkg::REQ_INS_AT, 32'h0000_0055, 5'd1);
        send_request(ile_pkg::REQ_DELETE, '0, 5'd31);
    endtask

    // Every edit at head, middle and tail, with extreme values and positions, plus reads and unknown types
    task automatic test_edit_ops();
        send_request(ile_pkg::REQ_INS_HEAD, 32'h7FFF_FFFF, 5'd9);
        send_request(ile_pkg::REQ_APPEND, 32'h8000_0000, 5'd0);
        send_request(ile_pkg::REQ_INS_AT, 32'hFFFF_FFFF, 5'd1);
        send_request(ile_pkg::REQ_INS_AT, 32'h0000_0000, 5'd3);   // position equal to length appends
        send_request(ile_pkg::REQ_INS_AT, 32'hA5A5_5A5A, 5'd31);  // past the tail
        send_request(ile_pkg::REQ_INS_HEAD, 32'h0000_0001, 5'd0);
        send_request(ile_pkg::REQ_READ, '0, 5'd0);
        send_request(ile_pkg::REQ_DELETE, '0, 5'd16);
        send_request(ile_pkg::REQ_DELETE, '0, 5'd5);              // equal to length
        send_request(3'd5, 32'hDEAD_BEEF, 5'd0);
        send_request(3'd6, 32'hFFFF_FFFF, 5'd31);
        send_request(3'd7, 32'h0000_0000, 5'd1);
        send_request(ile_pkg::REQ_DELETE, '0, 5'd2);
        send_request(ile_pkg::REQ_DELETE, '0, 5'd0);
        send_request(ile_pkg::REQ_DELETE, '0, 5'd2);              // tail
        send_request(ile_pkg::REQ_READ, 32'hFFFF_FFFF, 5'd31);
    endtask

    // Fill to capacity, try inserts when full, read all, then drain to empty
    task automatic test_full_list();
        while (shadow_len < LIST_CAP)
            send_request(ile_pkg::REQ_W'($urandom_range(ile_pkg::REQ_INS_HEAD,
                                                        ile_pkg::REQ_APPEND)),
                         pick_value(),
                         ile_pkg::POS_IN_W'($urandom_range(0, shadow_len)));
        send_request(ile_pkg::REQ_INS_HEAD, pick_value(), 5'd0);
        send_request(ile_pkg::REQ_INS_AT, pick_value(), 5'd31);   // full wins over bad position
        send_request(ile_pkg::REQ_APPEND, pick_value(), 5'd0);
        send_request(ile_pkg::REQ_READ, '0, 5'd0);
        while (shadow_len > 0)
            send_request(ile_pkg::REQ_DELETE, $urandom,
                         ile_pkg::POS_IN_W'($urandom_range(0, shadow_len - 1)));
        send_request(ile_pkg::REQ_READ, '0, 5'd0);
    endtask

    task automatic test_random_traffic(int unsigned n_items, int unsigned snd_pct,
                                       int unsigned rcv_pct);
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        repeat (n_items)
            random_request(55);
        wait_drained();
    endtask

    // Hold off the receiver while requests keep coming so the input stalls
    task automatic test_output_backpressure();
        snd_idle_pct    = 0;
        rcv_stall_pct   = 0;
        rcv_hold_cycles = LONG_HOLD;
        repeat (8)
            send_request(ile_pkg::REQ_APPEND, pick_value(), 5'd0);
        repeat (6)
            random_request(60);
        send_request(ile_pkg::REQ_READ, '0, 5'd0);
        wait_drained();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = '0;
        m_axis_tready   = 1'b0;
        mismatch_count  = 0;
        shadow_len      = 0;
        snd_idle_pct    = 0;
        rcv_stall_pct   = 0;
        rcv_hold_cycles = 0;
        foreach (shadow_list[i])
            shadow_list[i] = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_list();
        test_edit_ops();
        wait_drained();

        snd_idle_pct  = 31;
        rcv_stall_pct = 31;
        test_full_list();
        wait_drained();

        test_random_traffic(30, 0, 0);
        test_random_traffic(30, 69, 0);
        test_random_traffic(30, 0, 69);
        test_random_traffic(30, 31, 31);
        test_output_backpressure();

        // Allow any stray result to surface before the verdict
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived",
                            ile_pkg::VAL_W'(pending_results.size()), '0);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
